/* sv/crsfp_pkg.sv */
// Package of the CRSF frame parser: sizes, codes, types and the CRC bit step.
package crsfp_pkg;

  // Frame buffer sizing
  localparam int MAX_FRAME = 64;
  localparam int POS_W     = $clog2(MAX_FRAME);

  // Accepted length byte range
  localparam logic [7:0] LEN_MIN = 8'd2;
  localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 2);

  // Frame layout
  localparam logic [POS_W-1:0] TYPE_POS        = POS_W'(2);
  localparam logic [POS_W-1:0] RSSI_POS        = POS_W'(3);
  localparam logic [POS_W-1:0] LQ_POS          = POS_W'(5);
  localparam logic [POS_W-1:0] CHAN_FIRST_BYTE = POS_W'(3);
  localparam logic [7:0]       CHAN_LEN        = 8'd24;
  localparam logic [7:0]       LINK_MIN_LEN    = 8'd12;

  // Channel unpacking
  localparam int NUM_CHAN = 16;
  localparam int CHAN_W   = 11;
  localparam int IDX_W    = $clog2(NUM_CHAN);
  localparam int ACC_W    = CHAN_W - 1 + 8;
  localparam int NBITS_W  = $clog2(ACC_W + 1);

  // CRC-8 unit
  localparam logic [7:0] CRC_POLY          = 8'hD5;
  localparam int         CRC_BITS_PER_STEP = 2;
  localparam int         CRC_STEPS         = 8 / CRC_BITS_PER_STEP;
  localparam int         CRC_CNT_W         = $clog2(CRC_STEPS);

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC      = 2'd0;
  localparam logic [1:0] REG_CHAN_TYPE = 2'd1;
  localparam logic [1:0] REG_LINK_TYPE = 2'd2;

  typedef enum logic [1:0] {
    EV_CHANNEL = 2'd0,
    EV_LINK    = 2'd1,
    EV_CRC_ERR = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FINISH,
    ST_EMIT_ERR,
    ST_EMIT_LINK,
    ST_RD,
    ST_FILL,
    ST_EMIT_CH
  } state_e;

  // Control from the parser to the CRC unit
  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  // Advance the CRC by CRC_BITS_PER_STEP bits, MSB first
  function automatic logic [7:0] crc_advance(input logic [7:0] crc);
    logic [7:0] v;
    v = crc;
    for (int k = 0; k < CRC_BITS_PER_STEP; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

/* sv/crsf_frame_parser_top.sv */
// Top level of the CRSF frame parser: framing, frame buffer, decode and result register.
//
//   channel  direction  handshake               payload
//   rx       in         in_valid_i/in_stall_o   rx_byte_i
//   result   out        out_valid_o/out_stall_i event_kind_o .. last_o
//   config   in         cfg_we_i                cfg_index_i, cfg_wdata_i
//
// Sync and length bytes are taken as they come; a type or payload byte holds the input
// stalled while the CRC unit folds it in, 2 bits per cycle. The CRC byte is followed by
// the frame end check and, for a channels frame, by unpacking via the read port.
// Reset returns to hunting with all counters and the CRC at zero; no clearing pass.
// A stalled result holds the result register, and the byte input stalls whenever the
// parser is not idle, so also while the frame's next result waits for that register.
module crsf_frame_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         event_kind_o,
  output logic [3:0]         channel_index_o,
  output logic [10:0]        channel_value_o,
  output logic signed [7:0]  rssi_dbm_o,
  output logic [7:0]         link_quality_o,
  output logic [31:0]        good_channel_frames_o,
  output logic [31:0]        crc_error_count_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i
);

  localparam int PW = crsfp_pkg::POS_W;

  crsfp_pkg::state_e state_q, state_d;

  logic [7:0] sync_q, chan_type_q, link_type_q;

  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    type_q, rssi_raw_q, lq_q;
  logic [7:0]    crc_byte_q;
  logic [31:0]   chan_frames_q, chan_frames_d;
  logic [31:0]   crc_fail_q, crc_fail_d;

  logic [7:0]    mem [crsfp_pkg::MAX_FRAME];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic          rd_en;

  logic [PW-1:0]                    rd_addr_q, rd_addr_d;
  logic [crsfp_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic [crsfp_pkg::NBITS_W-1:0]    nbits_q, nbits_d;
  logic [crsfp_pkg::IDX_W-1:0]      ch_q, ch_d;

  logic                             out_valid_q;
  logic [1:0]                       kind_q;
  logic [3:0]                       idx_q;
  logic [10:0]                      val_q;
  logic [7:0]                       rssi_q, lqo_q;
  logic [31:0]                      good_q, errc_q;
  logic                             last_q;

  logic                             out_free, out_load;
  crsfp_pkg::event_kind_e           kind_d;
  logic [3:0]                       idx_d;
  logic [10:0]                      val_d;
  logic [7:0]                       rssi_d, lqo_d;
  logic                             last_d;

  crsfp_pkg::crc_ctrl_t             crc_ctrl;
  logic [7:0]                       crc_val;
  logic                             crc_busy;
  logic                             accept;
  logic                             frame_end;

  logic [crsfp_pkg::NBITS_W-1:0]    nbits_fill, nbits_emit;

  crsfp_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc_val),
    .busy_o (crc_busy)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= 8'd200;
      chan_type_q <= 8'd22;
      link_type_q <= 8'd20;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crsfp_pkg::REG_SYNC:      sync_q      <= cfg_wdata_i;
        crsfp_pkg::REG_CHAN_TYPE: chan_type_q <= cfg_wdata_i;
        crsfp_pkg::REG_LINK_TYPE: link_type_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != crsfp_pkg::ST_IDLE) || crc_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign frame_end  = (9'(pos_q) == (9'(len_q) + 9'd1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign nbits_fill = nbits_q + crsfp_pkg::NBITS_W'(8);
  assign nbits_emit = nbits_q - crsfp_pkg::NBITS_W'(crsfp_pkg::CHAN_W);

  // Sequence framing, frame end checks and channel unpacking
  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    len_d         = len_q;
    chan_frames_d = chan_frames_q;
    crc_fail_d    = crc_fail_q;
    rd_addr_d     = rd_addr_q;
    acc_d         = acc_q;
    nbits_d       = nbits_q;
    ch_d          = ch_q;
    crc_ctrl      = '{clear: 1'b0, start: 1'b0, data: rx_byte_i};
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    kind_d        = crsfp_pkg::EV_CHANNEL;
    idx_d         = 4'd0;
    val_d         = 11'd0;
    rssi_d        = 8'd0;
    lqo_d         = 8'd0;
    last_d        = 1'b1;
    case (state_q)
      crsfp_pkg::ST_IDLE: begin
        if (accept) begin
          if (pos_q == '0) begin
            if (rx_byte_i == sync_q) pos_d = PW'(1);
          end else if (pos_q == PW'(1)) begin
            if (rx_byte_i inside {[crsfp_pkg::LEN_MIN:crsfp_pkg::LEN_MAX]}) begin
              len_d          = rx_byte_i;
              pos_d          = PW'(2);
              crc_ctrl.clear = 1'b1;
            end else begin
              pos_d = '0;
            end
          end else if (frame_end) begin
            mem_we  = 1'b1;
            pos_d   = '0;
            state_d = crsfp_pkg::ST_FINISH;
          end else begin
            mem_we         = 1'b1;
            crc_ctrl.start = 1'b1;
            pos_d          = pos_q + 1'b1;
          end
        end
      end
      crsfp_pkg::ST_FINISH: begin
        if (crc_val != crc_byte_q) begin
          crc_fail_d = crc_fail_q + 32'd1;
          state_d    = crsfp_pkg::ST_EMIT_ERR;
        end else if (type_q == chan_type_q && len_q == crsfp_pkg::CHAN_LEN) begin
          chan_frames_d = chan_frames_q + 32'd1;
          rd_addr_d     = crsfp_pkg::CHAN_FIRST_BYTE;
          acc_d         = '0;
          nbits_d       = '0;
          ch_d          = '0;
          state_d       = crsfp_pkg::ST_RD;
        end else if (type_q == link_type_q && len_q >= crsfp_pkg::LINK_MIN_LEN) begin
          state_d = crsfp_pkg::ST_EMIT_LINK;
        end else begin
          state_d = crsfp_pkg::ST_IDLE;
        end
      end
      crsfp_pkg::ST_EMIT_ERR: begin
        kind_d = crsfp_pkg::EV_CRC_ERR;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = crsfp_pkg::ST_IDLE;
        end
      end
      crsfp_pkg::ST_EMIT_LINK: begin
        kind_d = crsfp_pkg::EV_LINK;
        rssi_d = 8'(8'd0 - rssi_raw_q);
        lqo_d  = lq_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = crsfp_pkg::ST_IDLE;
        end
      end
      crsfp_pkg::ST_RD: begin
        rd_en   = 1'b1;
        state_d = crsfp_pkg::ST_FILL;
      end
      crsfp_pkg::ST_FILL: begin
        // Append the byte above the bits still held
        acc_d     = acc_q | (crsfp_pkg::ACC_W'(rdata_q) << nbits_q);
        nbits_d   = nbits_fill;
        rd_addr_d = rd_addr_q + 1'b1;
        state_d   = (nbits_fill >= crsfp_pkg::NBITS_W'(crsfp_pkg::CHAN_W)) ?
                    crsfp_pkg::ST_EMIT_CH : crsfp_pkg::ST_RD;
      end
      crsfp_pkg::ST_EMIT_CH: begin
        kind_d = crsfp_pkg::EV_CHANNEL;
        idx_d  = 4'(ch_q);
        val_d  = acc_q[crsfp_pkg::CHAN_W-1:0];
        last_d = (ch_q == crsfp_pkg::IDX_W'(crsfp_pkg::NUM_CHAN - 1));
        if (out_free) begin
          out_load = 1'b1;
          acc_d    = acc_q >> crsfp_pkg::CHAN_W;
          nbits_d  = nbits_emit;
          ch_d     = ch_q + 1'b1;
          if (last_d) begin
            state_d = crsfp_pkg::ST_IDLE;
          end else if (nbits_emit >= crsfp_pkg::NBITS_W'(crsfp_pkg::CHAN_W)) begin
            state_d = crsfp_pkg::ST_EMIT_CH;
          end else begin
            state_d = crsfp_pkg::ST_RD;
          end
        end
      end
      default: state_d = crsfp_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= crsfp_pkg::ST_IDLE;
      pos_q         <= '0;
      len_q         <= 8'd0;
      chan_frames_q <= 32'd0;
      crc_fail_q    <= 32'd0;
      rd_addr_q     <= '0;
      acc_q         <= '0;
      nbits_q       <= '0;
      ch_q          <= '0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      len_q         <= len_d;
      chan_frames_q <= chan_frames_d;
      crc_fail_q    <= crc_fail_d;
      rd_addr_q     <= rd_addr_d;
      acc_q         <= acc_d;
      nbits_q       <= nbits_d;
      ch_q          <= ch_d;
    end
  end

  // Capture header bytes and the received CRC as they pass
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (pos_q == crsfp_pkg::TYPE_POS) type_q     <= rx_byte_i;
      if (pos_q == crsfp_pkg::RSSI_POS) rssi_raw_q <= rx_byte_i;
      if (pos_q == crsfp_pkg::LQ_POS)   lq_q       <= rx_byte_i;
      crc_byte_q <= rx_byte_i;
    end
  end

  // Frame buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[pos_q] <= rx_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr_q];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q <= kind_d;
      idx_q  <= idx_d;
      val_q  <= val_d;
      rssi_q <= rssi_d;
      lqo_q  <= lqo_d;
      good_q <= chan_frames_q;
      errc_q <= crc_fail_q;
      last_q <= last_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign event_kind_o          = kind_q;
  assign channel_index_o       = idx_q;
  assign channel_value_o       = val_q;
  assign rssi_dbm_o            = $signed(rssi_q);
  assign link_quality_o        = lqo_q;
  assign good_channel_frames_o = good_q;
  assign crc_error_count_o     = errc_q;
  assign last_o                = last_q;

`ifndef NO_ASSERTIONS
  // The CRC must be settled when the frame end is checked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crsfp_pkg::ST_FINISH) |-> !crc_busy)
    else $error("frame end checked while CRC unit busy");

  // The last channel result carries the top channel index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == crsfp_pkg::EV_CHANNEL && last_o)
      |-> (channel_index_o == 4'(crsfp_pkg::NUM_CHAN - 1)))
    else $error("last mark on wrong channel");

  // The error count moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((crc_fail_q == $past(crc_fail_q)) || (crc_fail_q == $past(crc_fail_q) + 32'd1)))
    else $error("CRC error count jumped");

  // Inside a frame the position never passes the CRC byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q >= PW'(2)) |-> (9'(pos_q) <= (9'(len_q) + 9'd1)))
    else $error("byte position past frame end");

  // The unpacking buffer never holds more bits than it can
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nbits_q <= crsfp_pkg::NBITS_W'(crsfp_pkg::ACC_W))
    else $error("channel bit buffer overflow");
`endif

endmodule

/* sv/crsfp_crc_unit.sv */
// CRC-8 unit that folds one byte into the running CRC in steps of CRC_BITS_PER_STEP bits.
module crsfp_crc_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crsfp_pkg::crc_ctrl_t ctrl_i,
  output logic [7:0]           crc_o,
  output logic                 busy_o
);

  logic [7:0]                     crc_q, crc_d;
  logic [crsfp_pkg::CRC_CNT_W-1:0] cnt_q, cnt_d;

  // Clear, start a byte with its first step, or run the remaining steps
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      crc_d = 8'h00;
      cnt_d = '0;
    end else if (ctrl_i.start) begin
      crc_d = crsfp_pkg::crc_advance(crc_q ^ ctrl_i.data);
      cnt_d = crsfp_pkg::CRC_CNT_W'(crsfp_pkg::CRC_STEPS - 1);
    end else if (cnt_q != '0) begin
      crc_d = crsfp_pkg::crc_advance(crc_q);
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 8'h00;
      cnt_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign crc_o  = crc_q;
  assign busy_o = (cnt_q != '0);

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the CRSF frame parser: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import crsfp_pkg::*;

  localparam int         SETTLE_CYCLES = 40;
  localparam int         END_CYCLES    = 100;
  localparam int         QUIET_LIMIT   = 5000;
  localparam int         HOLD_CYCLES   = 400;
  localparam logic [1:0] REG_SPARE     = 2'd3;
  localparam logic [8:0] FILL_RAND     = 9'h100;
  localparam logic [7:0] TYPE_PLAIN    = 8'h2A;

  typedef enum logic [2:0] {
    ROW_RAW,
    ROW_BADLEN,
    ROW_CHAN,
    ROW_LINK,
    ROW_PLAIN
  } row_e;

  // One received byte; the CRC byte of a frame may carry fixed expected fields
  typedef struct packed {
    logic [7:0]  data;
    logic        pinned;
    event_kind_e kind;
    logic [10:0] val;
    logic [7:0]  rssi;
    logic [7:0]  lq;
  } rx_beat_t;

  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  idx;
    logic [10:0] val;
    logic [7:0]  rssi;
    logic [7:0]  lq;
    logic [31:0] good;
    logic [31:0] errs;
    logic        last;
  } event_t;

  typedef struct packed {
    row_e        kind;
    logic [7:0]  flen;
    logic [8:0]  fill;
    logic        bad_crc;
    logic        pinned;
    event_kind_e ev;
    logic [10:0] val;
    logic [7:0]  rssi;
    logic [7:0]  lq;
  } row_t;

  // Directed frames at reset settings; fixed fields only where they are obvious
  localparam row_t DIRECTED [20] = '{
    '{ROW_RAW,    8'd0,  9'h000,    1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_RAW,    8'd0,  9'h0FF,    1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_BADLEN, 8'd0,  9'h000,    1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_BADLEN, 8'd1,  9'h000,    1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_BADLEN, 8'd63, 9'h000,    1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_BADLEN, 8'd255, 9'h000,   1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_BADLEN, 8'd200, 9'h000,   1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_CHAN,   8'd24, 9'h000,    1'b0, 1'b1, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_CHAN,   8'd24, 9'h0FF,    1'b0, 1'b1, EV_CHANNEL, 11'h7FF,  8'h00, 8'h00},
    '{ROW_CHAN,   8'd24, FILL_RAND, 1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_CHAN,   8'd24, FILL_RAND, 1'b1, 1'b1, EV_CRC_ERR, 11'd0,    8'h00, 8'h00},
    '{ROW_LINK,   8'd12, 9'h000,    1'b0, 1'b1, EV_LINK,    11'd0,    8'h00, 8'h00},
    '{ROW_LINK,   8'd62, 9'h080,    1'b0, 1'b1, EV_LINK,    11'd0,    8'h80, 8'h80},
    '{ROW_LINK,   8'd12, 9'h0FF,    1'b0, 1'b1, EV_LINK,    11'd0,    8'h01, 8'hFF},
    '{ROW_LINK,   8'd11, FILL_RAND, 1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_CHAN,   8'd23, FILL_RAND, 1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_CHAN,   8'd25, FILL_RAND, 1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_PLAIN,  8'd2,  9'h000,    1'b0, 1'b0, EV_CHANNEL, 11'd0,    8'h00, 8'h00},
    '{ROW_PLAIN,  8'd2,  9'h000,    1'b1, 1'b1, EV_CRC_ERR, 11'd0,    8'h00, 8'h00},
    '{ROW_LINK,   8'd62, FILL_RAND, 1'b1, 1'b1, EV_CRC_ERR, 11'd0,    8'h00, 8'h00}
  };

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i       = 8'd0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [1:0]         event_kind_o;
  logic [3:0]         channel_index_o;
  logic [10:0]        channel_value_o;
  logic signed [7:0]  rssi_dbm_o;
  logic [7:0]         link_quality_o;
  logic [31:0]        good_channel_frames_o;
  logic [31:0]        crc_error_count_o;
  logic               last_o;
  logic               cfg_we_i        = 1'b0;
  logic [1:0]         cfg_index_i     = 2'd0;
  logic [7:0]         cfg_wdata_i     = 8'd0;

  rx_beat_t           cur_beat        = '0;

  // Parser model state and settings
  logic [7:0]  sync_cfg      = 8'd200;
  logic [7:0]  chan_type_cfg = 8'd22;
  logic [7:0]  link_type_cfg = 8'd20;
  int unsigned frame_pos     = 0;
  logic [7:0]  frame_buf [MAX_FRAME];
  logic [7:0]  crc_acc       = 8'd0;
  logic [31:0] chan_frames   = 32'd0;
  logic [31:0] crc_fails     = 32'd0;

  event_t      pending_events [$];
  int          errors        = 0;
  int          events_seen   = 0;
  int          bytes_sent    = 0;
  int          frames_sent   = 0;
  int          settings_used = 1;
  int          snd_idle_pct  = 6;
  int          rcv_idle_pct  = 60;
  int          hold_req      = 0;
  int          hold_left     = 0;

  wire moved = (in_valid_i & ~in_stall_o) | (out_valid_o & ~out_stall_i);

  crsf_frame_parser_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .event_kind_o          (event_kind_o),
    .channel_index_o       (channel_index_o),
    .channel_value_o       (channel_value_o),
    .rssi_dbm_o            (rssi_dbm_o),
    .link_quality_o        (link_quality_o),
    .good_channel_frames_o (good_channel_frames_o),
    .crc_error_count_o     (crc_error_count_o),
    .last_o                (last_o),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Fold one byte into the CRC-8, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic rx_beat_t plain(input logic [7:0] b);
    rx_beat_t s;
    s      = '0;
    s.data = b;
    return s;
  endfunction

  function automatic event_t blank_event(input event_kind_e kind);
    event_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  // Advance the parser model by one byte and queue the events it causes
  task automatic parse_byte(input rx_beat_t s);
    event_t      found [$];
    event_t      r;
    logic [7:0]  b;
    logic [7:0]  flen;
    logic [23:0] w;
    int          bit_ofs;
    int          byt;
    b = s.data;
    if (frame_pos == 0) begin
      if (b == sync_cfg) begin
        frame_buf[0] = b;
        frame_pos    = 1;
      end
    end else if (frame_pos == 1) begin
      if (b < LEN_MIN || b > LEN_MAX) begin
        frame_pos = 0;
      end else begin
        frame_buf[1] = b;
        crc_acc      = 8'd0;
        frame_pos    = 2;
      end
    end else begin
      flen                 = frame_buf[1];
      frame_buf[frame_pos] = b;
      if (frame_pos == int'(flen) + 1) begin
        frame_pos = 0;
        if (crc_acc != b) begin
          crc_fails++;
          found.push_back(blank_event(EV_CRC_ERR));
        end else if (frame_buf[TYPE_POS] == chan_type_cfg && flen == CHAN_LEN) begin
          chan_frames++;
          for (int ch = 0; ch < NUM_CHAN; ch++) begin
            bit_ofs = ch * CHAN_W;
            byt     = int'(CHAN_FIRST_BYTE) + bit_ofs / 8;
            w       = {(byt + 2 <= int'(CHAN_LEN)) ? frame_buf[byt + 2] : 8'h00,
                       frame_buf[byt + 1], frame_buf[byt]};
            r       = blank_event(EV_CHANNEL);
            r.idx   = 4'(ch);
            r.val   = 11'(w >> (bit_ofs % 8));
            found.push_back(r);
          end
        end else if (frame_buf[TYPE_POS] == link_type_cfg && flen >= LINK_MIN_LEN) begin
          r      = blank_event(EV_LINK);
          r.rssi = 8'(0 - frame_buf[RSSI_POS]);
          r.lq   = frame_buf[LQ_POS];
          found.push_back(r);
        end
      end else begin
        crc_acc = crc8_byte(crc_acc, b);
        frame_pos++;
      end
    end
    // Stamp counters and the last mark, apply fixed fields, then queue
    foreach (found[i]) begin
      r      = found[i];
      r.good = chan_frames;
      r.errs = crc_fails;
      r.last = (i == found.size() - 1);
      if (s.pinned) begin
        r.kind = s.kind;
        r.val  = s.val;
        r.rssi = s.rssi;
        r.lq   = s.lq;
      end
      pending_events.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint seen);
    if (want != seen) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  // Predict on every accepted byte, compare every accepted result
  always @(posedge clk_i) begin : scoreboard
    event_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_byte(cur_beat);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          $display("%0t ns: unexpected result, kind %0d index %0d value %0d", $time,
                   event_kind_o, channel_index_o, channel_value_o);
          errors++;
        end else begin
          want = pending_events.pop_front();
          events_seen++;
          check_field("event_kind", want.kind, event_kind_o);
          check_field("channel_index", want.idx, channel_index_o);
          check_field("channel_value", want.val, channel_value_o);
          check_field("rssi_dbm", $signed(want.rssi), rssi_dbm_o);
          check_field("link_quality", want.lq, link_quality_o);
          check_field("good_channel_frames", want.good, good_channel_frames_o);
          check_field("crc_error_count", want.errs, crc_error_count_o);
          check_field("last", want.last, last_o);
        end
      end
    end
  end

  // Drive result stall: random, or a long hold when requested
  always @(posedge clk_i) begin : result_stall
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (moved) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("crsf_frame_parser_top regression: fail");
    $finish;
  end

  // Offer one byte, with random gaps ahead of it, and hold it until taken
  task automatic push_byte(input rx_beat_t s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= s.data;
    cur_beat   <= s;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Build and send one frame; the tail carries any fixed expected fields
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                            input logic [8:0] fill, input bit bad_crc, input rx_beat_t tail);
    logic [7:0] crc;
    logic [7:0] d;
    rx_beat_t   t;
    frames_sent++;
    push_byte(plain(sync_cfg));
    push_byte(plain(flen));
    crc = crc8_byte(8'd0, ftype);
    push_byte(plain(ftype));
    for (int p = 3; p <= int'(flen); p++) begin
      d   = fill[8] ? 8'($urandom_range(255)) : fill[7:0];
      crc = crc8_byte(crc, d);
      push_byte(plain(d));
    end
    t      = tail;
    t.data = bad_crc ? (crc ^ (8'h01 << $urandom_range(7))) : crc;
    push_byte(t);
  endtask

  task automatic run_row(input row_t row);
    rx_beat_t tail;
    tail        = '0;
    tail.pinned = row.pinned;
    tail.kind   = row.ev;
    tail.val    = row.val;
    tail.rssi   = row.rssi;
    tail.lq     = row.lq;
    case (row.kind)
      ROW_RAW: begin
        push_byte(plain(row.fill[7:0]));
      end
      ROW_BADLEN: begin
        push_byte(plain(sync_cfg));
        push_byte(plain(row.flen));
      end
      ROW_CHAN:  send_frame(chan_type_cfg, row.flen, row.fill, row.bad_crc, tail);
      ROW_LINK:  send_frame(link_type_cfg, row.flen, row.fill, row.bad_crc, tail);
      default:   send_frame(TYPE_PLAIN, row.flen, row.fill, row.bad_crc, tail);
    endcase
  endtask

  // Mostly well-formed frames with random content; some noise and broken frames
  task automatic random_traffic(input int n_bytes);
    int       stop_at;
    int       pick;
    bit       bad;
    int       n;
    rx_beat_t none;
    none    = '0;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      bad  = ($urandom_range(9) == 0);
      if (pick < 35) begin
        send_frame(chan_type_cfg, CHAN_LEN, FILL_RAND, bad, none);
      end else if (pick < 55) begin
        send_frame(link_type_cfg, 8'($urandom_range(LINK_MIN_LEN, LEN_MAX)), FILL_RAND, bad,
                   none);
      end else if (pick < 68) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(LEN_MIN, LEN_MAX)), FILL_RAND,
                   bad, none);
      end else if (pick < 80) begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(plain(8'($urandom_range(255))));
      end else if (pick < 90) begin
        push_byte(plain(sync_cfg));
        push_byte(plain($urandom_range(1) ? 8'($urandom_range(1)) : 8'($urandom_range(63, 255))));
      end else begin
        // Cut a frame short; the parser eats what follows as its body
        push_byte(plain(sync_cfg));
        push_byte(plain(8'($urandom_range(LEN_MIN, LEN_MAX))));
        n = $urandom_range(1, 5);
        repeat (n) push_byte(plain(8'($urandom_range(255))));
      end
    end
  endtask

  // Drop valid and wait until every expected result is out and the block is quiet
  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SYNC:      sync_cfg      = val;
      REG_CHAN_TYPE: chan_type_cfg = val;
      REG_LINK_TYPE: link_type_cfg = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] sync_v, input logic [7:0] chan_v,
                               input logic [7:0] link_v);
    cfg_write(REG_SYNC, sync_v);
    cfg_write(REG_CHAN_TYPE, chan_v);
    cfg_write(REG_LINK_TYPE, link_v);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: directed frames, then random traffic
    for (int i = 0; i < $size(DIRECTED); i++) begin
      run_row(DIRECTED[i]);
    end
    random_traffic(150);
    drain(SETTLE_CYCLES);

    // Extreme settings; unused index must be ignored
    cfg_write(REG_SPARE, 8'h5A);
    apply_setting(8'h00, 8'hFF, 8'h00);

    // Hold results off long enough for the input to back up
    hold_req = HOLD_CYCLES;
    repeat (3) send_frame(chan_type_cfg, CHAN_LEN, FILL_RAND, 1'b0, '0);
    drain(SETTLE_CYCLES);
    random_traffic(150);
    drain(SETTLE_CYCLES);

    // Shared type code; swap the idle pattern
    snd_idle_pct = 60;
    rcv_idle_pct = 6;
    apply_setting(8'hFF, 8'h7E, 8'h7E);
    random_traffic(150);
    drain(SETTLE_CYCLES);

    // Back to reset values, no idling
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    apply_setting(8'd200, 8'd22, 8'd20);
    random_traffic(150);
    drain(END_CYCLES);

    $display("Sent %0d bytes in %0d frames over %0d register settings, incl. a long hold.",
             bytes_sent, frames_sent, settings_used);
    $display("Checked %0d results: %0d good channel frames, %0d CRC failures.",
             events_seen, chan_frames, crc_fails);
    if (errors == 0) begin
      $display("crsf_frame_parser_top regression: pass");
    end else begin
      $display("crsf_frame_parser_top regression: fail");
    end
    $finish;
  end

endmodule
